/* sv/tlcd_pkg.sv */
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared widths, state codes and controller/datapath interface types for the
// two-way LRU cache directory.
// ----------------------------------------------------------------------------
package tlcd_pkg;

  // address split: | tag | set | offset |
  localparam int ADDR_W     = 32;
  localparam int LINE_BYTES = 32;
  localparam int SET_COUNT  = 64;
  localparam int OFFSET_W   = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SET_COUNT);
  localparam int BLOCK_W    = ADDR_W - OFFSET_W;
  localparam int TAG_W      = BLOCK_W - SET_W;

  // stream widths
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_FIELDS_W = OFFSET_W + BLOCK_W + SET_W + 1 + TAG_W + 1 + 1 + TAG_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  typedef struct packed {
    logic load;    // capture the incoming address
    logic read;    // read both tag ways of the set
    logic commit;  // update directory, load result register
  } tlcd_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being drained
  } tlcd_sts_t;

endpackage

/* sv/tlcd_ctrl.sv */
// ----------------------------------------------------------------------------
// tlcd_ctrl
// Sequencer: accept address, read tag ways, commit update and result.
// ----------------------------------------------------------------------------
module tlcd_ctrl
  import tlcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  tlcd_sts_t sts,
  output tlcd_cmd_t cmd
);

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the result register can take the item
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/tlcd_datapath.sv */
// ----------------------------------------------------------------------------
// tlcd_datapath
// Address split, tag memories, valid and LRU bits, hit/fill/evict decision
// and the result register.
// ----------------------------------------------------------------------------
module tlcd_datapath
  import tlcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  tlcd_cmd_t              cmd,
  output tlcd_sts_t              sts,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [ADDR_W-1:0]    addr;
  logic [SET_W-1:0]     set_idx;
  logic [TAG_W-1:0]     tag;

  logic [TAG_W-1:0]     tag_mem0 [SET_COUNT];
  logic [TAG_W-1:0]     tag_mem1 [SET_COUNT];
  logic [TAG_W-1:0]     rd0;
  logic [TAG_W-1:0]     rd1;

  logic [1:0]           line_valid [SET_COUNT];
  logic [SET_COUNT-1:0] recent_way;

  logic                 v0, v1, hit0, hit1, miss, way, ev_valid;
  logic [TAG_W-1:0]     ev_tag;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= s_tdata[ADDR_W-1:0];
    end
  end

  assign set_idx = addr[OFFSET_W +: SET_W];
  assign tag     = addr[ADDR_W-1 -: TAG_W];

  // tag memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd0 <= tag_mem0[set_idx];
      rd1 <= tag_mem1[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && miss && !way) begin
      tag_mem0[set_idx] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && miss && way) begin
      tag_mem1[set_idx] <= tag;
    end
  end

  // lookup and replacement choice
  always_comb begin
    v0       = line_valid[set_idx][0];
    v1       = line_valid[set_idx][1];
    hit0     = v0 && (rd0 == tag);
    hit1     = v1 && (rd1 == tag);
    miss     = !(hit0 || hit1);
    ev_valid = 1'b0;
    ev_tag   = '0;
    if (!miss) begin
      way = !hit0;
    end else if (!v0) begin
      way = 1'b0;
    end else if (!v1) begin
      way = 1'b1;
    end else begin
      way      = !recent_way[set_idx];
      ev_valid = 1'b1;
      ev_tag   = way ? rd1 : rd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_way <= '0;
      for (int i = 0; i < SET_COUNT; i++) begin
        line_valid[i] <= 2'b00;
      end
    end else if (cmd.commit) begin
      recent_way[set_idx] <= way;
      if (miss) begin
        line_valid[set_idx][way] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                  ev_tag, ev_valid, miss, tag, way, set_idx,
                  addr[ADDR_W-1:OFFSET_W], addr[OFFSET_W-1:0]};
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;

endmodule

/* sv/two_way_lru_cache_directory.sv */
// ----------------------------------------------------------------------------
// two_way_lru_cache_directory
// Two-way set-associative cache directory, 64 sets of 32-byte lines, with
// LRU replacement. One byte address in, one lookup result out.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[31:0] byte_address
//  m_*     | out | m_tvalid/m_tready  | m_tdata[87:0] lookup result
//
//  Each item passes three steps: accept, tag memory read (one registered read
//  port per way), then directory update and result load.
//  The result register frees the input side: a new address is accepted
//  while the previous result still waits on m_tready.
//  If the result register is still full at update time, the update holds
//  until m_tready drains it.
//  rst is synchronous; valid and LRU bits sit in flops and clear in the
//  reset cycle, so no clearing pass follows. Tag memories are not reset.
//
module two_way_lru_cache_directory
  import tlcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // slave side
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] byte_address
  // master side
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [4:0] byte_offset, [31:5] block_number,
                                            // [37:32] set_index, [38] way_used,
                                            // [59:39] address_tag, [60] is_miss,
                                            // [61] evicted_valid, [82:62] evicted_tag,
                                            // [87:83] zero
);

  tlcd_cmd_t cmd;
  tlcd_sts_t sts;

  tlcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlcd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* sv/tlcd_checker.sv */
// ----------------------------------------------------------------------------
// tlcd_checker
// Port-level checks for the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module tlcd_checker
  import tlcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[60] |-> !m_tdata[61] && (m_tdata[82:62] == '0))
    else $error("hit reports eviction");

  // no eviction: evicted tag reads zero
  a_evict_tag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[61] |-> m_tdata[82:62] == '0)
    else $error("evicted tag without eviction");

  // a replaced line cannot hold the requested tag
  a_evict_differs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[61] |-> m_tdata[60] && (m_tdata[82:62] != m_tdata[59:39]))
    else $error("evicted line matched the request");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind two_way_lru_cache_directory tlcd_checker u_tlcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
